// ----- design/spd_pkg.sv -----
// Shared types and constants for the sensor packet deframer.
`default_nettype none
package spd_pkg;

   // Frame geometry
   localparam int PAYLOAD_BYTES = 1206;
   localparam int TS_BYTES      = 8;
   localparam int CNT_W         = 11;
   localparam logic [7:0] MARKER_RESET = 8'h1b;

   // Depth of the word queue between front and back
   localparam int QDEPTH  = 4;
   localparam int QPTR_W  = $clog2(QDEPTH);
   localparam int QCNT_W  = $clog2(QDEPTH + 1);

   // Parser phase
   typedef enum logic [2:0] {
      PH_HUNT,
      PH_TIME,
      PH_LENLO,
      PH_LENHI,
      PH_DATA,
      PH_CHECK
   } phase_type;

   // What the back end has to do with one word
   typedef enum logic [2:0] {
      OP_STRAY,
      OP_START,
      OP_TIME,
      OP_NONE,
      OP_BADLEN,
      OP_DATA,
      OP_CHECK
   } op_type;

   // Frame status codes
   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_BAD_START = 2'd1,
      ST_BAD_LEN   = 2'd2,
      ST_BAD_SUM   = 2'd3
   } status_type;

   // Classified word handed from front to back
   typedef struct packed {
      op_type           op;
      logic [7:0]       data;
      logic [CNT_W-1:0] index;
   } token_type;

endpackage
`default_nettype wire

// ----- design/sensor_packet_deframer_core.sv -----
// Top level of the sensor packet deframer.
//
// Byte-stream frame receiver. Each frame is a start marker byte, 8 timestamp
// bytes (LSB first), a 2-byte little-endian length, 1206 payload bytes and a
// modulo-256 payload sum. Every accepted input word gives exactly one result
// word: a passed-through payload byte, an end-of-frame status (with the
// timestamp, except on a stray byte), or an empty word for other header bytes.
// Input: req_data_byte is taken when req_push is high and req_full is low.
// Output: the oldest result sits on rsp_* while rsp_empty is low; rsp_pop
// takes it. csr_data writes the start marker when csr_valid is high
// (csr_ready is always high); write it only while the block is idle.
// A word accepted on req_* is first written into the queue and then moved into
// the result register on rsp_*; throughput is one word per cycle while rsp_pop
// drains the result register.
// A 4-word queue between parser and execute stage absorbs output stalls;
// req_full rises once it and the result register are full.
// Reset (synchronous) empties both sides, sets the marker to 0x1b and
// returns the parser to hunting for the start byte.
`default_nettype none
module sensor_packet_deframer_core
   import spd_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_push,
   output logic                  req_full,
   input  wire logic [7:0]       req_data_byte,
   output logic                  rsp_empty,
   input  wire logic             rsp_pop,
   output logic [7:0]            rsp_payload_byte,
   output logic                  rsp_payload_valid,
   output logic [CNT_W-1:0]      rsp_payload_index,
   output logic                  rsp_frame_end,
   output logic [1:0]            rsp_frame_status,
   output logic [63:0]           rsp_timestamp_bits,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [7:0]       csr_data
);

   logic       marker_ff;
   logic [7:0] start_marker_ff;
   logic       accept;
   token_type  front_token, head_token;
   logic       q_empty, q_take;

   assign csr_ready = 1'b1;
   assign accept    = req_push && !req_full;

   // Start marker register
   always_ff @(posedge clock) begin
      if (reset) begin
         start_marker_ff <= MARKER_RESET;
         marker_ff       <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         start_marker_ff <= csr_data;
         marker_ff       <= 1'b1;
      end
   end

   spd_front u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .data_byte    (req_data_byte),
      .start_marker (start_marker_ff),
      .token        (front_token)
   );

   spd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (accept),
      .wr_token (front_token),
      .rd_en    (q_take),
      .rd_token (head_token),
      .full     (req_full),
      .empty    (q_empty)
   );

   spd_back u_back (
      .clock              (clock),
      .reset              (reset),
      .tok_avail          (!q_empty),
      .tok                (head_token),
      .tok_take           (q_take),
      .rsp_pop            (rsp_pop),
      .rsp_empty          (rsp_empty),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_payload_valid  (rsp_payload_valid),
      .rsp_payload_index  (rsp_payload_index),
      .rsp_frame_end      (rsp_frame_end),
      .rsp_frame_status   (rsp_frame_status),
      .rsp_timestamp_bits (rsp_timestamp_bits)
   );

   // Reset leaves both sides empty
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("deframer not empty after reset");

   // A word is never both payload and frame end
   a_kind_excl: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> !(rsp_frame_end && rsp_payload_valid))
      else $error("payload word flagged as frame end");

   // Payload index stays inside the frame
   a_index_range: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_payload_valid) |-> (rsp_payload_index < CNT_W'(PAYLOAD_BYTES)))
      else $error("payload index out of range");

   // Status and timestamp are zero on words that do not end a frame
   a_quiet_fields: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_frame_end) |->
         (rsp_frame_status == 2'(ST_OK) && rsp_timestamp_bits == '0))
      else $error("status or timestamp set without frame end");

   // A marker write sets the marker flag and stores the byte; the flag only tracks whether a write has happened
   a_marker_written: assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_ready) |=> (marker_ff && start_marker_ff == $past(csr_data)))
      else $error("start marker write lost");

endmodule
`default_nettype wire

// ----- design/spd_front.sv -----
// Front end: tracks the frame phase and classifies each incoming word.
`default_nettype none
module spd_front
   import spd_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       accept,
   input  wire logic [7:0] data_byte,
   input  wire logic [7:0] start_marker,
   output token_type       token
);

   phase_type        phase_ff, phase_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [7:0]       len_low_ff, len_low_in;
   logic             len_ok;

   assign len_ok = ({data_byte, len_low_ff} == 16'(PAYLOAD_BYTES));

   // Next phase, counter and length low byte
   always_comb begin
      phase_in   = phase_ff;
      count_in   = count_ff;
      len_low_in = len_low_ff;
      if (accept) begin
         unique case (phase_ff)
            PH_HUNT: begin
               count_in = '0;
               if (data_byte == start_marker) begin
                  phase_in   = PH_TIME;
                  len_low_in = '0;
               end
            end
            PH_TIME: begin
               if (count_ff == CNT_W'(TS_BYTES - 1)) begin
                  count_in = '0;
                  phase_in = PH_LENLO;
               end else begin
                  count_in = count_ff + 1'b1;
               end
            end
            PH_LENLO: begin
               len_low_in = data_byte;
               phase_in   = PH_LENHI;
            end
            PH_LENHI: begin
               count_in = '0;
               phase_in = len_ok ? PH_DATA : PH_HUNT;
            end
            PH_DATA: begin
               if (count_ff == CNT_W'(PAYLOAD_BYTES - 1)) begin
                  count_in = '0;
                  phase_in = PH_CHECK;
               end else begin
                  count_in = count_ff + 1'b1;
               end
            end
            PH_CHECK: begin
               count_in = '0;
               phase_in = PH_HUNT;
            end
            default: begin
               count_in = '0;
               phase_in = PH_HUNT;
            end
         endcase
      end
   end

   // Word classification
   always_comb begin
      token.data  = data_byte;
      token.index = count_ff;
      unique case (phase_ff)
         PH_HUNT:  token.op = (data_byte == start_marker) ? OP_START : OP_STRAY;
         PH_TIME:  token.op = OP_TIME;
         PH_LENLO: token.op = OP_NONE;
         PH_LENHI: token.op = len_ok ? OP_NONE : OP_BADLEN;
         PH_DATA:  token.op = OP_DATA;
         PH_CHECK: token.op = OP_CHECK;
         default:  token.op = (data_byte == start_marker) ? OP_START : OP_STRAY;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HUNT;
         count_ff   <= '0;
         len_low_ff <= '0;
      end else begin
         phase_ff   <= phase_in;
         count_ff   <= count_in;
         len_low_ff <= len_low_in;
      end
   end

endmodule
`default_nettype wire

// ----- design/spd_queue.sv -----
// Short register queue of classified words between front and back.
`default_nettype none
module spd_queue
   import spd_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      wr_en,
   input  wire token_type wr_token,
   input  wire logic      rd_en,
   output token_type      rd_token,
   output logic           full,
   output logic           empty
);

   token_type         mem_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign full     = (count_ff == QCNT_W'(QDEPTH));
   assign empty    = (count_ff == '0);
   assign rd_token = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (wr_en && !rd_en) begin
         count_in = count_ff + 1'b1;
      end else if (rd_en && !wr_en) begin
         count_in = count_ff - 1'b1;
      end
   end

   // Pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (wr_en) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (rd_en) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= wr_token;
      end
   end

endmodule
`default_nettype wire

// ----- design/spd_back.sv -----
// Back end: assembles timestamp and checksum and drives the result register.
`default_nettype none
module spd_back
   import spd_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              tok_avail,
   input  wire token_type         tok,
   output logic                   tok_take,
   input  wire logic              rsp_pop,
   output logic                   rsp_empty,
   output logic [7:0]             rsp_payload_byte,
   output logic                   rsp_payload_valid,
   output logic [CNT_W-1:0]       rsp_payload_index,
   output logic                   rsp_frame_end,
   output logic [1:0]             rsp_frame_status,
   output logic [63:0]            rsp_timestamp_bits
);

   logic             full_ff;
   logic [63:0]      ts_ff, ts_in;
   logic [7:0]       sum_ff, sum_in;
   logic [7:0]       pbyte_ff, pbyte_in;
   logic             pvalid_ff, pvalid_in;
   logic [CNT_W-1:0] pindex_ff, pindex_in;
   logic             fend_ff, fend_in;
   status_type       status_ff, status_in;
   logic [63:0]      tsout_ff, tsout_in;

   // Load a new word when the result register is free or being drained
   assign tok_take = tok_avail && (!full_ff || rsp_pop);

   // Execute one word
   always_comb begin
      ts_in     = ts_ff;
      sum_in    = sum_ff;
      pbyte_in  = '0;
      pvalid_in = 1'b0;
      pindex_in = '0;
      fend_in   = 1'b0;
      status_in = ST_OK;
      tsout_in  = '0;
      unique case (tok.op)
         OP_STRAY: begin
            fend_in   = 1'b1;
            status_in = ST_BAD_START;
         end
         OP_START: begin
            ts_in  = '0;
            sum_in = '0;
         end
         OP_TIME: ts_in = {tok.data, ts_ff[63:8]};
         OP_NONE: ;
         OP_BADLEN: begin
            fend_in   = 1'b1;
            status_in = ST_BAD_LEN;
            tsout_in  = ts_ff;
         end
         OP_DATA: begin
            pbyte_in  = tok.data;
            pvalid_in = 1'b1;
            pindex_in = tok.index;
            sum_in    = sum_ff + tok.data;
         end
         OP_CHECK: begin
            fend_in   = 1'b1;
            status_in = (tok.data == sum_ff) ? ST_OK : ST_BAD_SUM;
            tsout_in  = ts_ff;
         end
         default: ;
      endcase
   end

   // Frame state and result occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= 1'b0;
         ts_ff   <= '0;
         sum_ff  <= '0;
      end else begin
         if (tok_take) begin
            full_ff <= 1'b1;
            ts_ff   <= ts_in;
            sum_ff  <= sum_in;
         end else if (rsp_pop) begin
            full_ff <= 1'b0;
         end
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (tok_take) begin
         pbyte_ff  <= pbyte_in;
         pvalid_ff <= pvalid_in;
         pindex_ff <= pindex_in;
         fend_ff   <= fend_in;
         status_ff <= status_in;
         tsout_ff  <= tsout_in;
      end
   end

   assign rsp_empty          = !full_ff;
   assign rsp_payload_byte   = pbyte_ff;
   assign rsp_payload_valid  = pvalid_ff;
   assign rsp_payload_index  = pindex_ff;
   assign rsp_frame_end      = fend_ff;
   assign rsp_frame_status   = 2'(status_ff);
   assign rsp_timestamp_bits = tsout_ff;

endmodule
`default_nettype wire
